@@ src/stc_pkg.sv @@
// shared types and constants for the share target divider
`timescale 1ns / 1ps
package stc_pkg;

  localparam int unsigned DIV_W     = 32;   // divisor and remainder width
  localparam int unsigned QUO_W     = 240;  // significant quotient bits
  localparam int unsigned BPC       = 4;    // quotient bits resolved per cell
  localparam int unsigned NUM_CELLS = QUO_W / BPC;
  // dividend 0xffff * 2^224: below bit 240 the top sixteen bits are ones
  localparam int unsigned TOP_ONES  = 16;

  typedef struct packed {
    logic [DIV_W-1:0] div;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } stage_t;

endpackage

@@ src/stc_cell.sv @@
// one divider cell: resolves four quotient bits by restoring division
`timescale 1ns / 1ps
module stc_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  stc_pkg::stage_t stage_i,
  output logic            valid_o,
  output stc_pkg::stage_t stage_o
);

  logic            valid_q;
  stc_pkg::stage_t stage_q;
  stc_pkg::stage_t stage_d;

  always_comb begin
    logic [stc_pkg::DIV_W:0]   trial;
    logic [stc_pkg::DIV_W-1:0] r;
    logic [stc_pkg::BPC-1:0]   qb;
    logic                      dbit;
    r  = stage_i.rem;
    qb = '0;
    for (int j = 0; j < int'(stc_pkg::BPC); j++) begin
      // dividend bit taken in at this step, fixed by the cell position
      dbit  = ((CELL_IDX * stc_pkg::BPC + j) < stc_pkg::TOP_ONES);
      trial = {r, dbit};
      if (trial >= {1'b0, stage_i.div}) begin
        trial = trial - {1'b0, stage_i.div};
        qb[stc_pkg::BPC-1-j] = 1'b1;
      end
      r = trial[stc_pkg::DIV_W-1:0];
    end
    stage_d.div = stage_i.div;
    stage_d.rem = r;
    stage_d.quo = {stage_i.quo[stc_pkg::QUO_W-stc_pkg::BPC-1:0], qb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ src/share_target_from_difficulty_core.sv @@
// top level: pipelined share target divider with stream ports
`timescale 1ns / 1ps
// share target from difficulty
//
// a request on the slave stream carries a 32-bit share difficulty (zero acts
// as one). the master stream returns floor(0xffff * 2^224 / difficulty) as
// 240 quotient bits: four little-endian words, word 0 in the lowest bits.
//
// the divider is a row of 60 cells; each cell holds one request and resolves
// four quotient bits from the top in each cycle that the row moves, then hands
// divisor, remainder and partial quotient to its neighbor. an output register
// follows. a new request is taken in every cycle that the row moves.
//
// the whole row moves together. it keeps moving while the output register is
// empty, being taken, or the last cell is empty, so a waiting result does not
// stop intake until the last cell holds a request as well. s_axis_tready
// depends on m_axis_tready combinationally.
// reset clears all valid flags; requests in flight are dropped.
module share_target_from_difficulty_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [stc_pkg::DIV_W-1:0] s_axis_tdata,  // difficulty[31:0]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // target_word_0[63:0], target_word_1[127:64], target_word_2[191:128],
  // target_word_3[239:192]
  output logic [stc_pkg::QUO_W-1:0] m_axis_tdata
);

  logic                                  adv;
  logic                                  out_en;
  logic            [stc_pkg::NUM_CELLS:0] valid_chain;
  stc_pkg::stage_t [stc_pkg::NUM_CELLS:0] stage_chain;
  logic                                  out_valid_q;
  logic            [stc_pkg::QUO_W-1:0]  out_data_q;

  // output register can load when empty or when its result is taken
  assign out_en = !out_valid_q || m_axis_tready;

  // row advances unless a held result blocks a full last cell
  assign adv = out_en || !valid_chain[stc_pkg::NUM_CELLS];
  assign s_axis_tready = adv;

  // head of the row: zero difficulty divides as one
  assign valid_chain[0]     = s_axis_tvalid;
  assign stage_chain[0].div = (s_axis_tdata == '0) ? stc_pkg::DIV_W'(1) : s_axis_tdata;
  assign stage_chain[0].rem = '0;
  assign stage_chain[0].quo = '0;

  for (genvar k = 0; k < stc_pkg::NUM_CELLS; k++) begin : g_cell
    stc_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(valid_chain[k]),
      .stage_i(stage_chain[k]),
      .valid_o(valid_chain[k+1]),
      .stage_o(stage_chain[k+1])
    );
  end

  // output register, holds its result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= valid_chain[stc_pkg::NUM_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && valid_chain[stc_pkg::NUM_CELLS]) begin
      out_data_q <= stage_chain[stc_pkg::NUM_CELLS].quo;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ src/stc_checker.sv @@
// port-level checks for the share target divider
`timescale 1ns / 1ps
module stc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [stc_pkg::QUO_W-1:0] m_axis_tdata
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // an empty output register never blocks intake
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("intake blocked with empty output");

  // a result being taken always lets the row move
  a_take_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("intake blocked while result taken");

  // the smallest target is still nonzero
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata != '0))
    else $error("zero target delivered");

endmodule

bind share_target_from_difficulty_core stc_checker u_stc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

@@ bench/tb_share_target_from_difficulty_core.sv @@
// self-checking bench for the pipelined share target divider
`timescale 1ns / 1ps
module tb_share_target_from_difficulty_core;

  localparam int unsigned CLK_HALF_NS    = 2;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned RANDOM_ITEMS   = 550;
  localparam int unsigned PIPE_LATENCY   = 61;
  localparam int unsigned SETTLE_CYCLES  = 2 * PIPE_LATENCY;
  localparam int unsigned TAIL_ITEMS     = 70;   // no idling for the last requests
  localparam int unsigned LONG_HOLD_AT   = 160;  // request count that starts the long stall
  localparam int unsigned LONG_HOLD_LEN  = 300;
  localparam int unsigned DRAIN_AT       = 330;  // request count where the sender drains
  localparam int unsigned MAX_BURST      = 18;
  // dividend 0xffff * 2^224, seen as eight 32-bit chunks: only the top one is set
  localparam bit [31:0]   DIVIDEND_TOP   = 32'h0000_ffff;
  localparam int unsigned DIV_CHUNKS     = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // slave stream: difficulty requests
  logic                      s_valid = 1'b0;
  logic                      s_ready;
  logic [stc_pkg::DIV_W-1:0] s_data = '0;   // difficulty[31:0]
  // master stream: share targets
  logic                      m_valid;
  logic                      m_ready = 1'b0;
  // target_word_0[63:0], target_word_1[127:64], target_word_2[191:128],
  // target_word_3[239:192]
  logic [stc_pkg::QUO_W-1:0] m_data;

  // requests waiting to be offered, and targets waiting to come back
  bit [31:0]                 difficulty_queue[$];
  bit [stc_pkg::QUO_W-1:0]   target_queue[$];

  int unsigned total_requests = 0;
  int unsigned sent_cnt       = 0;
  int unsigned checked_cnt    = 0;
  int unsigned error_cnt      = 0;
  int unsigned tx_gap         = 0;
  int unsigned rx_gap         = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_done = 1'b0;
  bit          drain_done     = 1'b0;
  int unsigned max_in_flight  = 0;
  bit          stalled_seen   = 1'b0;

  always #(CLK_HALF_NS) clk = ~clk;

  share_target_from_difficulty_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  // long division of 0xffff * 2^224 by the difficulty, 32 bits per step
  // from the top; the remainder always fits in 32 bits
  function automatic bit [stc_pkg::QUO_W-1:0] share_target(bit [31:0] difficulty);
    bit [63:0]  divisor;
    bit [63:0]  remainder;
    bit [63:0]  partial;
    bit [31:0]  chunk;
    bit [255:0] quotient;
    divisor   = (difficulty == 32'd0) ? 64'd1 : {32'd0, difficulty};
    remainder = '0;
    quotient  = '0;
    for (int i = DIV_CHUNKS - 1; i >= 0; i--) begin
      chunk     = (i == DIV_CHUNKS - 1) ? DIVIDEND_TOP : 32'd0;
      partial   = {remainder[31:0], chunk};
      quotient[i*32 +: 32] = 32'(partial / divisor);
      remainder = partial % divisor;
    end
    return quotient[stc_pkg::QUO_W-1:0];
  endfunction

  // random difficulty, weighted toward the corners of the divider
  function automatic bit [31:0] random_difficulty();
    bit [31:0] pick;
    case ($urandom_range(0, 9)) inside
      [0:3]:      pick = $urandom;
      4:          pick = $urandom_range(0, 255);
      5:          pick = $urandom_range(0, 65535);
      6:          pick = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
      7:          pick = 32'hffff_ffff - $urandom_range(0, 1000);
      8:          pick = $urandom >> $urandom_range(0, 31);
      default:    pick = ~($urandom >> $urandom_range(0, 31));
    endcase
    return pick;
  endfunction

  // append one difficulty to the pending requests
  function automatic void add_difficulty(bit [31:0] difficulty);
    difficulty_queue.insert(difficulty_queue.size(), difficulty);
  endfunction

  task automatic report_mismatch(string what, bit [63:0] got, bit [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    error_cnt++;
  endtask

  // stimulus: directed corners first, then random difficulties
  initial begin
    add_difficulty(32'd0);           // zero acts as one
    add_difficulty(32'd1);
    add_difficulty(32'd2);
    add_difficulty(32'd3);
    add_difficulty(32'd7);
    add_difficulty(32'd255);
    add_difficulty(32'd256);
    add_difficulty(32'h0000_ffff);   // cancels the dividend top
    add_difficulty(32'h0001_0000);
    add_difficulty(32'h0001_0001);
    add_difficulty(32'h5555_5555);
    add_difficulty(32'haaaa_aaaa);
    add_difficulty(32'h7fff_ffff);
    add_difficulty(32'h8000_0000);
    add_difficulty(32'h8000_0001);
    add_difficulty(32'hffff_fffe);
    add_difficulty(32'hffff_ffff);   // smallest target
    add_difficulty(32'h0000_0000);
    add_difficulty(32'hdead_beef);
    add_difficulty(32'h1234_5678);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_difficulty(random_difficulty());
    end
    total_requests = difficulty_queue.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // every request accepted, then every target returned
    wait (difficulty_queue.size() == 0 && sent_cnt == total_requests);
    wait (target_queue.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (target_queue.size() != 0) begin
      $display("%0d targets never arrived", target_queue.size());
      error_cnt++;
    end
    $display("covered %0d difficulty requests and %0d targets, zero and all-ones included",
             sent_cnt, checked_cnt);
    $display("peak requests in flight %0d, input backpressure %s",
             max_in_flight, stalled_seen ? "seen" : "not seen");
    if (error_cnt == 0) begin
      $display("share_target_from_difficulty_core test passed");
    end else begin
      $display("share_target_from_difficulty_core test failed");
    end
    $finish;
  end

  // driver: offers the next difficulty once the current one is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_valid && s_ready) begin
        target_queue.insert(target_queue.size(), share_target(s_data));
        sent_cnt++;
      end
      if (s_valid && !s_ready) begin
        stalled_seen = 1'b1;
      end
      if (target_queue.size() > max_in_flight) begin
        max_in_flight = target_queue.size();
      end

      if (!(s_valid && !s_ready)) begin
        if (sent_cnt == DRAIN_AT && !drain_done) begin
          // pause until the pipe has emptied completely
          s_valid <= 1'b0;
          if (target_queue.size() == 0) begin
            drain_done = 1'b1;
          end
        end else if (tx_gap > 0 && long_hold_left == 0) begin
          s_valid <= 1'b0;
          tx_gap--;
        end else if (difficulty_queue.size() > 0) begin
          s_valid <= 1'b1;
          s_data  <= difficulty_queue.pop_front();
          if (sent_cnt + TAIL_ITEMS < total_requests && $urandom_range(0, 5) == 0) begin
            tx_gap = $urandom_range(1, MAX_BURST);
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, one long hold so the row fills and blocks intake
  always @(posedge clk) begin
    if (rst_n) begin
      if (long_hold_left > 0) begin
        m_ready <= 1'b0;
        long_hold_left--;
      end else if (!long_hold_done && sent_cnt >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        long_hold_left = LONG_HOLD_LEN;
        m_ready <= 1'b0;
      end else if (sent_cnt + TAIL_ITEMS >= total_requests) begin
        m_ready <= 1'b1;
      end else if (rx_gap > 0) begin
        m_ready <= 1'b0;
        rx_gap--;
      end else begin
        m_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) begin
          rx_gap = $urandom_range(1, MAX_BURST);
        end
      end
    end
  end

  // monitor: each returned target against the oldest expectation
  always @(posedge clk) begin
    bit [stc_pkg::QUO_W-1:0] want;
    if (rst_n && m_valid && m_ready) begin
      if (target_queue.size() == 0) begin
        $display("[%0t] target %h with no request pending", $time, m_data);
        error_cnt++;
      end else begin
        want = target_queue.pop_front();
        if (m_data[63:0] !== want[63:0]) begin
          report_mismatch("target_word_0", m_data[63:0], want[63:0]);
        end
        if (m_data[127:64] !== want[127:64]) begin
          report_mismatch("target_word_1", m_data[127:64], want[127:64]);
        end
        if (m_data[191:128] !== want[191:128]) begin
          report_mismatch("target_word_2", m_data[191:128], want[191:128]);
        end
        if (m_data[239:192] !== want[239:192]) begin
          report_mismatch("target_word_3", {16'd0, m_data[239:192]},
                          {16'd0, want[239:192]});
        end
        checked_cnt++;
      end
    end
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("share_target_from_difficulty_core test failed");
    $finish;
  end

endmodule
